@@ rtl/chm_pkg.sv @@
// Package for the chained hash map engine: command codes, default sizes,
// and the controller/datapath command and status structs. No dependencies.
package chm_pkg;

  localparam int NumBucketsDef = 64;
  localparam int WaysDef       = 4;
  localparam int KeyBitsDef    = 32;
  localparam int ValueBitsDef  = 32;
  localparam int CfgBits       = 7;
  localparam int CmdBits       = 2;
  localparam int OutBits       = 32;

  typedef enum logic [CmdBits-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_FIND     = 2'd1,
    CMD_ERASE    = 2'd2,
    CMD_ERASE_KV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;       // capture request, start modulo
    logic mod_step;   // one restoring-division step
    logic rd;         // issue slot read at current way
    logic way_inc;    // advance way
    logic way_clr;    // restart way scan
    logic wr_upd;     // write value at current way
    logic wr_new;     // write key/value/valid at free way
    logic wr_clr;     // clear valid at current way
    logic res_hit;    // capture find/erase hit result
    logic res_add;    // capture insert added result
    logic res_upd;    // capture insert updated result
    logic res_full;   // capture bucket full result
    logic res_miss;   // capture miss result
    logic clr_step;   // advance the reset sweep counter by one slot
  } chm_ctl_t;

  typedef struct packed {
    logic mod_done;
    logic way_last;
    logic match;      // current slot valid and key matches (and value for kv)
    logic free;       // current slot invalid
    logic free_seen;  // a free slot was recorded in the bucket
    logic clr_last;
    cmd_t cmd;
  } chm_sts_t;

endpackage

@@ rtl/chm_ctrl.sv @@
// Controller state machine for the chained hash map engine.
// Depends on chm_pkg for command/status structs.
module chm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              cfg_ready,
  input  chm_pkg::chm_sts_t sts,
  output chm_pkg::chm_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_READ, S_CHECK, S_FILL, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          ctl.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          ctl.way_clr = 1'b1;
          state_nxt   = S_READ;
        end else begin
          ctl.mod_step = 1'b1;
        end
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.match) begin
          unique case (sts.cmd)
            chm_pkg::CMD_INSERT: begin
              ctl.wr_upd  = 1'b1;
              ctl.res_upd = 1'b1;
            end
            chm_pkg::CMD_FIND: ctl.res_hit = 1'b1;
            default: begin
              ctl.wr_clr  = 1'b1;
              ctl.res_hit = 1'b1;
            end
          endcase
          state_nxt = S_OUT;
        end else if (!sts.way_last) begin
          ctl.way_inc = 1'b1;
          state_nxt   = S_READ;
        end else if (sts.cmd == chm_pkg::CMD_INSERT) begin
          if (sts.free_seen || sts.free) state_nxt = S_FILL;
          else begin
            ctl.res_full = 1'b1;
            state_nxt    = S_OUT;
          end
        end else begin
          ctl.res_miss = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_FILL: begin
        ctl.wr_new  = 1'b1;
        ctl.res_add = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/chm_dp.sv @@
// Datapath for the chained hash map engine: bucket modulo, slot memories,
// valid bits and result registers. Depends on chm_pkg.
module chm_dp #(
  parameter int NUM_BUCKETS = chm_pkg::NumBucketsDef,
  parameter int WAYS        = chm_pkg::WaysDef,
  parameter int KEY_BITS    = chm_pkg::KeyBitsDef,
  parameter int VALUE_BITS  = chm_pkg::ValueBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  chm_pkg::chm_ctl_t           ctl,
  output chm_pkg::chm_sts_t           sts,
  input  logic [chm_pkg::CmdBits-1:0] in_cmd,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic                        cfg_we,
  input  logic [chm_pkg::CfgBits-1:0] cfg_data,
  output logic                        out_status,
  output logic [chm_pkg::OutBits-1:0] out_found_value,
  output logic                        out_bucket_full
);

  localparam int BktW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int Slots  = NUM_BUCKETS * WAYS;
  localparam int SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CntW   = $clog2(KEY_BITS + 1);
  localparam int DivW   = BktW + 1;

  logic [KEY_BITS-1:0]   slot_key_m [Slots];
  logic [VALUE_BITS-1:0] slot_val_m [Slots];
  logic [Slots-1:0]      slot_vld_r;

  logic [chm_pkg::CfgBits-1:0] bcnt_r;
  logic [DivW-1:0]             div_eff;

  chm_pkg::cmd_t         cmd_r;
  logic [KEY_BITS-1:0]   key_r, quo_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [DivW-1:0]       rem_r;
  logic [CntW-1:0]       cnt_r;
  logic [WayW-1:0]       way_r, free_way_r;
  logic                  free_seen_r;
  logic                  rvld_r;
  logic [KEY_BITS-1:0]   rkey_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic [SlotW-1:0]      clr_r;
  logic [SlotW-1:0]      cur_slot, free_slot;
  logic [BktW-1:0]       bucket;
  logic [DivW:0]         rem_sh;

  always_comb begin
    if (bcnt_r == '0) div_eff = DivW'(1);
    else if (32'(bcnt_r) > NUM_BUCKETS) div_eff = DivW'(NUM_BUCKETS);
    else div_eff = DivW'(bcnt_r);
  end

  assign rem_sh    = {rem_r, quo_r[KEY_BITS-1]};
  assign bucket    = rem_r[BktW-1:0];
  assign cur_slot  = SlotW'(32'(bucket) * WAYS + 32'(way_r));
  assign free_slot = SlotW'(32'(bucket) * WAYS + 32'(free_way_r));

  always_ff @(posedge clk) begin
    if (!rst_n) bcnt_r <= 7'd64;
    else if (cfg_we) bcnt_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= chm_pkg::cmd_t'(in_cmd);
      key_r <= in_key;
      quo_r <= in_key;
      val_r <= in_value;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (ctl.mod_step) begin
      if ({1'b0, rem_sh} >= {1'b0, div_eff, 1'b0} >> 1 &&
          rem_sh >= {1'b0, div_eff})
        rem_r <= DivW'(rem_sh - {1'b0, div_eff});
      else
        rem_r <= DivW'(rem_sh);
      quo_r <= {quo_r[KEY_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.way_clr) begin
      way_r       <= '0;
      free_seen_r <= 1'b0;
    end else if (ctl.way_inc) begin
      way_r <= way_r + 1'b1;
      if (!rvld_r && !free_seen_r) begin
        free_seen_r <= 1'b1;
        free_way_r  <= way_r;
      end
    end
    if (sts.free && !free_seen_r && !ctl.way_inc && !ctl.way_clr) free_way_r <= way_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rkey_r <= slot_key_m[cur_slot];
      rval_r <= slot_val_m[cur_slot];
      rvld_r <= slot_vld_r[cur_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_upd) slot_val_m[cur_slot] <= val_r;
    if (ctl.wr_new) begin
      slot_key_m[free_slot] <= key_r;
      slot_val_m[free_slot] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      clr_r      <= '0;
    end else begin
      if (ctl.clr_step) clr_r <= clr_r + 1'b1;
      if (ctl.wr_new) slot_vld_r[free_slot] <= 1'b1;
      if (ctl.wr_clr) slot_vld_r[cur_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_hit || ctl.res_add || ctl.res_upd || ctl.res_full || ctl.res_miss) begin
      out_status      <= ctl.res_hit || ctl.res_add;
      out_bucket_full <= ctl.res_full;
      out_found_value <= (ctl.res_hit && cmd_r == chm_pkg::CMD_FIND) ?
                         chm_pkg::OutBits'(rval_r) : '0;
    end
  end

  always_comb begin
    sts.mod_done  = (32'(cnt_r) == KEY_BITS);
    sts.way_last  = (32'(way_r) == WAYS - 1);
    sts.free      = !rvld_r;
    sts.free_seen = free_seen_r;
    sts.clr_last  = (32'(clr_r) == Slots - 1);
    sts.cmd       = cmd_r;
    sts.match     = rvld_r && (rkey_r == key_r) &&
                    (cmd_r != chm_pkg::CMD_ERASE_KV || rval_r == val_r);
  end

endmodule

@@ rtl/chained_hash_map_engine.sv @@
// Top level of the chained hash map engine: ties controller and datapath.
// Depends on chm_pkg, chm_ctrl and chm_dp.
//
//   channel | direction | fields                              | handshake
//   in_     | input     | cmd, key, value                     | valid / stall
//   out_    | output    | status, found_value, bucket_full    | valid / stall
//   cfg_    | input     | data (number of buckets in use)     | valid / ready
//
// A request runs a one-bit-per-cycle restoring modulo of the key, then a read and
// compare per way of the bucket, over one memory port. After reset a sweep over all
// NUM_BUCKETS*WAYS slots runs first, and requests are stalled until it ends.
// A new request is taken only once the previous result has left the output.
module chained_hash_map_engine #(
  parameter int NUM_BUCKETS = chm_pkg::NumBucketsDef,
  parameter int WAYS        = chm_pkg::WaysDef,
  parameter int KEY_BITS    = chm_pkg::KeyBitsDef,
  parameter int VALUE_BITS  = chm_pkg::ValueBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [chm_pkg::CmdBits-1:0] in_cmd,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic [VALUE_BITS-1:0]       in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [chm_pkg::OutBits-1:0] out_found_value,
  output logic                        out_bucket_full,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [chm_pkg::CfgBits-1:0] cfg_data
);

  chm_pkg::chm_ctl_t ctl;
  chm_pkg::chm_sts_t sts;

  chm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cfg_ready, .sts, .ctl
  );

  chm_dp #(
    .NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS),
    .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk, .rst_n, .ctl, .sts, .in_cmd, .in_key, .in_value,
    .cfg_we(cfg_valid && cfg_ready), .cfg_data,
    .out_status, .out_found_value, .out_bucket_full
  );

endmodule
